/* rtl/mas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants
// Item structs, status codes and widths for the matrix average-scale
// normalizer.
// ----------------------------------------------------------------------------
package mas_pkg;

    localparam int DATA_W    = 16;
    localparam int LEN_W     = 16;   // floor sqrt of a 32-bit sum of squares
    localparam int SUMSQ_W   = 32;
    localparam int LENSUM_W  = 18;   // three row lengths
    localparam int UNITY_DEF = 4096;

    // x / 3 == (x * DIV3_MUL) >> DIV3_SH for x < 2^19
    localparam int DIV3_SH   = 20;
    localparam logic [18:0] DIV3_MUL = 19'd349526;
    localparam int PROD3_W   = LENSUM_W + 19;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] r0_c0;
        logic signed [DATA_W-1:0] r0_c1;
        logic signed [DATA_W-1:0] r0_c2;
        logic signed [DATA_W-1:0] r1_c0;
        logic signed [DATA_W-1:0] r1_c1;
        logic signed [DATA_W-1:0] r1_c2;
        logic signed [DATA_W-1:0] r2_c0;
        logic signed [DATA_W-1:0] r2_c1;
        logic signed [DATA_W-1:0] r2_c2;
    } t_mat_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] n0_c0;
        logic signed [DATA_W-1:0] n0_c1;
        logic signed [DATA_W-1:0] n0_c2;
        logic signed [DATA_W-1:0] n1_c0;
        logic signed [DATA_W-1:0] n1_c1;
        logic signed [DATA_W-1:0] n1_c2;
        logic signed [DATA_W-1:0] n2_c0;
        logic signed [DATA_W-1:0] n2_c1;
        logic signed [DATA_W-1:0] n2_c2;
        logic [1:0]               status;
    } t_mat_out;

endpackage

/* rtl/matrix_average_scale_normalize_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_average_scale_normalize_top
// Fully pipelined: one matrix item per cycle, with a depth set by the
// 16-stage square root in each row lane and the NUM_W-stage divider in
// each element lane. The whole pipe advances together and holds while a
// finished item waits on a stalled output.
// ----------------------------------------------------------------------------
module matrix_average_scale_normalize_top
    import mas_pkg::*;
#(
    parameter int UNITY = UNITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_mat_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_mat_out o_data
);

    localparam int NUM_W   = $clog2(32768 * UNITY + 1);
    localparam int ROW_LAT = 2 + LEN_W;
    localparam int LAT     = ROW_LAT + 1 + NUM_W + 1 + 1;

    logic w_en;
    logic r_vld [0:LAT-1];

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // row lanes
    logic [LEN_W-1:0] w_len [0:2];

    mas_rowlen u_row0 (.i_clk(i_clk), .i_en(w_en), .i_a(i_data.r0_c0),
                       .i_b(i_data.r0_c1), .i_c(i_data.r0_c2), .o_len(w_len[0]));
    mas_rowlen u_row1 (.i_clk(i_clk), .i_en(w_en), .i_a(i_data.r1_c0),
                       .i_b(i_data.r1_c1), .i_c(i_data.r1_c2), .o_len(w_len[1]));
    mas_rowlen u_row2 (.i_clk(i_clk), .i_en(w_en), .i_a(i_data.r2_c0),
                       .i_b(i_data.r2_c1), .i_c(i_data.r2_c2), .o_len(w_len[2]));

    // matrix rides alongside the row lanes
    t_mat_in r_mat [0:ROW_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mat[0] <= i_data;
            for (int k = 1; k <= ROW_LAT; k++) r_mat[k] <= r_mat[k-1];
        end
    end

    // merge: average of row lengths, divide by 3 via reciprocal
    logic [LENSUM_W-1:0] w_lensum;
    logic [PROD3_W-1:0]  r_prod;
    logic [LEN_W-1:0]    w_avg;

    assign w_lensum = LENSUM_W'(w_len[0]) + LENSUM_W'(w_len[1]) + LENSUM_W'(w_len[2]);
    assign w_avg    = r_prod[DIV3_SH +: LEN_W];

    always_ff @(posedge i_clk) begin
        if (w_en) r_prod <= PROD3_W'(w_lensum) * PROD3_W'(DIV3_MUL);
    end

    logic r_zero [0:NUM_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero[0] <= (w_avg == '0);
            for (int k = 1; k <= NUM_W; k++) r_zero[k] <= r_zero[k-1];
        end
    end

    // element lanes
    logic signed [DATA_W-1:0] w_elem [0:8];
    logic signed [DATA_W-1:0] w_q    [0:8];
    logic [8:0]               w_sat;

    assign w_elem[0] = r_mat[ROW_LAT].r0_c0;
    assign w_elem[1] = r_mat[ROW_LAT].r0_c1;
    assign w_elem[2] = r_mat[ROW_LAT].r0_c2;
    assign w_elem[3] = r_mat[ROW_LAT].r1_c0;
    assign w_elem[4] = r_mat[ROW_LAT].r1_c1;
    assign w_elem[5] = r_mat[ROW_LAT].r1_c2;
    assign w_elem[6] = r_mat[ROW_LAT].r2_c0;
    assign w_elem[7] = r_mat[ROW_LAT].r2_c1;
    assign w_elem[8] = r_mat[ROW_LAT].r2_c2;

    for (genvar gi = 0; gi < 9; gi++) begin : g_div
        mas_divlane #(.UNITY(UNITY)) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_elem (w_elem[gi]),
            .i_avg  (w_avg),
            .o_q    (w_q[gi]),
            .o_sat  (w_sat[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zero[NUM_W]) begin
                o_data <= {{(9*DATA_W){1'b0}}, ST_ZERO};
            end else begin
                o_data.n0_c0  <= w_q[0];
                o_data.n0_c1  <= w_q[1];
                o_data.n0_c2  <= w_q[2];
                o_data.n1_c0  <= w_q[3];
                o_data.n1_c1  <= w_q[4];
                o_data.n1_c2  <= w_q[5];
                o_data.n2_c0  <= w_q[6];
                o_data.n2_c1  <= w_q[7];
                o_data.n2_c2  <= w_q[8];
                o_data.status <= (|w_sat) ? ST_SAT : ST_OK;
            end
        end
    end

endmodule

/* rtl/mas_rowlen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_rowlen: row length lane
// Squares and sums one row, then a 16-stage pipelined floor square root,
// one result bit per stage.
// ----------------------------------------------------------------------------
module mas_rowlen
    import mas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic signed [DATA_W-1:0] i_c,
    output logic [LEN_W-1:0]         o_len
);

    logic [SUMSQ_W-2:0] r_sq_a, r_sq_b, r_sq_c;
    logic [SUMSQ_W-1:0] r_sumsq;
    logic signed [2*DATA_W-1:0] w_pa, w_pb, w_pc;

    assign w_pa = i_a * i_a;
    assign w_pb = i_b * i_b;
    assign w_pc = i_c * i_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_a  <= w_pa[SUMSQ_W-2:0];
            r_sq_b  <= w_pb[SUMSQ_W-2:0];
            r_sq_c  <= w_pc[SUMSQ_W-2:0];
            r_sumsq <= SUMSQ_W'(r_sq_a) + SUMSQ_W'(r_sq_b) + SUMSQ_W'(r_sq_c);
        end
    end

    wire [SUMSQ_W-1:0] w_v    [0:LEN_W];
    wire [LEN_W:0]     w_rem  [0:LEN_W];
    wire [LEN_W-1:0]   w_root [0:LEN_W];

    assign w_v[0]    = r_sumsq;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar gi = 0; gi < LEN_W; gi++) begin : g_stage
        logic [SUMSQ_W-1:0] r_v;
        logic [LEN_W:0]     r_rem;
        logic [LEN_W-1:0]   r_root;
        logic [LEN_W+2:0]   n_t;
        logic [LEN_W+2:0]   n_trial;

        always_comb begin
            n_t     = {w_rem[gi], w_v[gi][SUMSQ_W-1 -: 2]};
            n_trial = {1'b0, w_root[gi], 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v <= {w_v[gi][SUMSQ_W-3:0], 2'b00};
                if (n_t >= n_trial) begin
                    r_rem  <= (LEN_W+1)'(n_t - n_trial);
                    r_root <= {w_root[gi][LEN_W-2:0], 1'b1};
                end else begin
                    r_rem  <= n_t[LEN_W:0];
                    r_root <= {w_root[gi][LEN_W-2:0], 1'b0};
                end
            end
        end

        assign w_v[gi+1]    = r_v;
        assign w_rem[gi+1]  = r_rem;
        assign w_root[gi+1] = r_root;
    end

    assign o_len = w_root[LEN_W];

endmodule

/* rtl/mas_divlane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_divlane: element divide lane
// elem * UNITY / avg, truncating toward zero, as a pipelined restoring
// divider on the magnitude (one quotient bit per stage), then saturation.
// ----------------------------------------------------------------------------
module mas_divlane
    import mas_pkg::*;
#(
    parameter int UNITY = UNITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_elem,
    input  logic [LEN_W-1:0]         i_avg,
    output logic signed [DATA_W-1:0] o_q,
    output logic                     o_sat
);

    localparam int NUM_W = $clog2(32768 * UNITY + 1);
    localparam logic signed [DATA_W:0] C_UNITY = (DATA_W+1)'(UNITY);

    logic signed [2*DATA_W:0] w_prod;
    logic [2*DATA_W:0]        w_mag;

    assign w_prod = i_elem * C_UNITY;
    assign w_mag  = w_prod[2*DATA_W] ? (2*DATA_W+1)'(-w_prod) : w_prod;

    wire [NUM_W-1:0] w_num [0:NUM_W];
    wire [NUM_W-1:0] w_quo [0:NUM_W];
    wire [LEN_W-1:0] w_rem [0:NUM_W];
    wire [LEN_W-1:0] w_den [0:NUM_W];
    wire             w_neg [0:NUM_W];

    assign w_num[0] = w_mag[NUM_W-1:0];
    assign w_quo[0] = '0;
    assign w_rem[0] = '0;
    assign w_den[0] = i_avg;
    assign w_neg[0] = w_prod[2*DATA_W];

    for (genvar gi = 0; gi < NUM_W; gi++) begin : g_stage
        logic [NUM_W-1:0] r_num, r_quo;
        logic [LEN_W-1:0] r_rem, r_den;
        logic             r_neg;
        logic [LEN_W:0]   n_t;

        assign n_t = {w_rem[gi], w_num[gi][NUM_W-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num <= {w_num[gi][NUM_W-2:0], 1'b0};
                r_den <= w_den[gi];
                r_neg <= w_neg[gi];
                if (n_t >= {1'b0, w_den[gi]}) begin
                    r_rem <= LEN_W'(n_t - {1'b0, w_den[gi]});
                    r_quo <= {w_quo[gi][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_t[LEN_W-1:0];
                    r_quo <= {w_quo[gi][NUM_W-2:0], 1'b0};
                end
            end
        end

        assign w_num[gi+1] = r_num;
        assign w_quo[gi+1] = r_quo;
        assign w_rem[gi+1] = r_rem;
        assign w_den[gi+1] = r_den;
        assign w_neg[gi+1] = r_neg;
    end

    logic [NUM_W-1:0] w_q;
    logic             w_hi;

    assign w_q  = w_quo[NUM_W];
    assign w_hi = |w_q[NUM_W-1:DATA_W-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_neg[NUM_W]) begin
                // -32768 is still in range
                if (w_hi && (w_q != NUM_W'(32768))) begin
                    o_q   <= 16'sh8000;
                    o_sat <= 1'b1;
                end else begin
                    o_q   <= DATA_W'(-w_q[DATA_W-1:0]);
                    o_sat <= 1'b0;
                end
            end else begin
                if (w_hi) begin
                    o_q   <= 16'sh7fff;
                    o_sat <= 1'b1;
                end else begin
                    o_q   <= w_q[DATA_W-1:0];
                    o_sat <= 1'b0;
                end
            end
        end
    end

endmodule

/* rtl/mas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_checker: port-level checks
// Watches the top level's ports; bound to every instance of the top.
// ----------------------------------------------------------------------------
module mas_checker
    import mas_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_stall,
    input logic     o_valid,
    input logic     i_stall,
    input t_mat_out o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output item changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled output item");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status != 2'd3)
        else $error("undefined status code");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_ZERO |->
            o_data.n0_c0 == 0 && o_data.n0_c1 == 0 && o_data.n0_c2 == 0 &&
            o_data.n1_c0 == 0 && o_data.n1_c1 == 0 && o_data.n1_c2 == 0 &&
            o_data.n2_c0 == 0 && o_data.n2_c1 == 0 && o_data.n2_c2 == 0)
        else $error("zero scale item with nonzero elements");

endmodule

bind matrix_average_scale_normalize_top mas_checker u_mas_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for matrix_average_scale_normalize_top
// Sends signed 3x3 matrices in random bursts, stalls the output on its own
// pattern, and compares each normalized matrix and status against a local
// predictor of row lengths, average scale, division and saturation.
// ----------------------------------------------------------------------------
module tb_top;
    import mas_pkg::*;

    localparam int UNITY      = UNITY_DEF;
    localparam int LATENCY    = 60;
    localparam int IDLE_LIMIT = 5000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_mat_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_mat_out o_data;

    t_mat_in  pending_q[$];
    t_mat_out expected_q[$];
    int       err_cnt;
    int       idle_cycles;
    int       burst_left;
    int       gap_left;
    int       stall_mode;
    bit       stim_done;

    matrix_average_scale_normalize_top #(.UNITY(UNITY)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint floor_sqrt(longint v);
        longint root;
        root = 0;
        for (int b = 17; b >= 0; b--) begin
            if ((root + (longint'(1) << b)) * (root + (longint'(1) << b)) <= v)
                root = root + (longint'(1) << b);
        end
        return root;
    endfunction

    function automatic t_mat_out normalize_matrix(t_mat_in m);
        longint   el[9];
        longint   q;
        longint   lensum;
        longint   avg;
        bit       sat;
        t_mat_out res;
        el[0] = m.r0_c0; el[1] = m.r0_c1; el[2] = m.r0_c2;
        el[3] = m.r1_c0; el[4] = m.r1_c1; el[5] = m.r1_c2;
        el[6] = m.r2_c0; el[7] = m.r2_c1; el[8] = m.r2_c2;
        lensum = 0;
        for (int r = 0; r < 3; r++)
            lensum += floor_sqrt(el[3*r]*el[3*r] + el[3*r+1]*el[3*r+1]
                                 + el[3*r+2]*el[3*r+2]);
        avg = lensum / 3;
        res = '0;
        sat = 1'b0;
        if (avg == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        for (int i = 0; i < 9; i++) begin
            q = (el[i] * UNITY) / avg;   // SV division truncates toward zero
            if (q > 32767) begin
                q = 32767;
                sat = 1'b1;
            end else if (q < -32768) begin
                q = -32768;
                sat = 1'b1;
            end
            el[i] = q;
        end
        res.n0_c0 = el[0][15:0]; res.n0_c1 = el[1][15:0]; res.n0_c2 = el[2][15:0];
        res.n1_c0 = el[3][15:0]; res.n1_c1 = el[4][15:0]; res.n1_c2 = el[5][15:0];
        res.n2_c0 = el[6][15:0]; res.n2_c1 = el[7][15:0]; res.n2_c2 = el[8][15:0];
        res.status = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic t_mat_in fill_matrix(logic signed [15:0] v);
        t_mat_in m;
        m = {9{v}};
        return m;
    endfunction

    function automatic logic signed [15:0] rand_elem(int scale);
        case (scale)
            0:       return $urandom_range(0, 4) - 2;
            1:       return $urandom_range(0, 512) - 256;
            2:       return $urandom_range(0, 8192) - 4096;
            default: return $urandom();
        endcase
    endfunction

    // Directed cases, then random matrices of mixed magnitude.
    initial begin
        t_mat_in m;
        int      scale;
        pending_q.push_back('0);
        pending_q.push_back(fill_matrix(16'sh7FFF));
        pending_q.push_back(fill_matrix(-16'sh8000));
        pending_q.push_back(fill_matrix(16'sd1));
        pending_q.push_back(fill_matrix(-16'sd1));
        pending_q.push_back(fill_matrix(16'sd2));
        m = '0; m.r0_c0 = 16'sd2; m.r1_c1 = 16'sd2; m.r2_c2 = 16'sd2;
        pending_q.push_back(m);
        // one big element and a tiny one: the tiny element's quotient truncates to zero
        m = '0; m.r0_c0 = -16'sh8000; m.r1_c1 = 16'sd1;
        pending_q.push_back(m);
        m = '0; m.r0_c0 = 16'sh7FFF;
        pending_q.push_back(m);
        m = '0; m.r0_c0 = 16'sd3;
        pending_q.push_back(m);
        m = '0; m.r0_c0 = 16'sd4096; m.r1_c1 = 16'sd4096; m.r2_c2 = -16'sd4096;
        pending_q.push_back(m);
        m = '0; m.r0_c0 = 16'sh5555; m.r1_c1 = -16'sh2AAB; m.r2_c2 = 16'sh7F00;
        pending_q.push_back(m);
        m = '0; m.r0_c0 = 16'sd100; m.r0_c1 = -16'sd30000; m.r2_c2 = 16'sd1;
        pending_q.push_back(m);
        for (int n = 0; n < 500; n++) begin
            scale = $urandom_range(0, 3);
            m.r0_c0 = rand_elem(scale); m.r0_c1 = rand_elem(scale);
            m.r0_c2 = rand_elem(scale); m.r1_c0 = rand_elem(scale);
            m.r1_c1 = rand_elem(scale); m.r1_c2 = rand_elem(scale);
            m.r2_c0 = rand_elem(scale); m.r2_c1 = rand_elem(scale);
            m.r2_c2 = rand_elem(scale);
            // sometimes clear rows to unbalance the lengths
            if ($urandom_range(0, 4) == 0) begin
                m.r1_c0 = '0; m.r1_c1 = '0; m.r1_c2 = '0;
                if ($urandom_range(0, 1)) begin
                    m.r2_c0 = '0; m.r2_c1 = '0; m.r2_c2 = '0;
                end
            end
            pending_q.push_back(m);
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        stim_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !i_valid);
        wait (expected_q.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
        stim_done = 1'b1;
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Driver: bursts of items separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_data     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid)
                expected_q.push_back(normalize_matrix(i_data));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_q.size() > 0) begin
                i_valid <= 1'b1;
                i_data  <= pending_q.pop_front();
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: modes of none, light, heavy, and long holds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ($urandom_range(0, 15) != 0) ? i_stall : ~i_stall;
            endcase
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        t_mat_out want;
        if (!i_rst_n) begin
            err_cnt     <= 0;
            idle_cycles <= 0;
        end else begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_data.n0_c0 !== want.n0_c0) report_mismatch("n0_c0", o_data.n0_c0, want.n0_c0);
                    if (o_data.n0_c1 !== want.n0_c1) report_mismatch("n0_c1", o_data.n0_c1, want.n0_c1);
                    if (o_data.n0_c2 !== want.n0_c2) report_mismatch("n0_c2", o_data.n0_c2, want.n0_c2);
                    if (o_data.n1_c0 !== want.n1_c0) report_mismatch("n1_c0", o_data.n1_c0, want.n1_c0);
                    if (o_data.n1_c1 !== want.n1_c1) report_mismatch("n1_c1", o_data.n1_c1, want.n1_c1);
                    if (o_data.n1_c2 !== want.n1_c2) report_mismatch("n1_c2", o_data.n1_c2, want.n1_c2);
                    if (o_data.n2_c0 !== want.n2_c0) report_mismatch("n2_c0", o_data.n2_c0, want.n2_c0);
                    if (o_data.n2_c1 !== want.n2_c1) report_mismatch("n2_c1", o_data.n2_c1, want.n2_c1);
                    if (o_data.n2_c2 !== want.n2_c2) report_mismatch("n2_c2", o_data.n2_c2, want.n2_c2);
                    if (o_data.status !== want.status) report_mismatch("status", o_data.status, want.status);
                end
            end
            if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
rtl/mas_pkg.sv
rtl/mas_rowlen.sv
rtl/mas_divlane.sv
rtl/matrix_average_scale_normalize_top.sv
rtl/mas_checker.sv
bench/tb_top.sv
